// File: rtl/core/gm3_pkg.sv
package gm3_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 8;

	// Register file
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int FW_W      = 11;
	localparam int FH_W      = 13;
	localparam int FW_RESET  = 640;
	localparam int FH_RESET  = 480;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// Frame geometry
	localparam int ROW_W      = 12;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_SIZE   = 3;

	// Stream payloads
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 16;
	localparam int OUT_W     = 12;
	localparam int OUT_MAX   = 4095;

	// Magnitude scale: root of 256*(sx^2+sy^2) divided by this
	localparam int DIVISOR   = 6;
	localparam int FRAC_SHIFT = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW,
		ST_MAG,
		ST_WAIT,
		ST_OUT
	} core_state_t;

	typedef enum logic [2:0] {
		MG_IDLE,
		MG_SQ,
		MG_SUM,
		MG_ROOT,
		MG_DIV,
		MG_DONE
	} mag_state_t;

endpackage

// File: rtl/core/gm3_line_store.sv
module gm3_line_store import gm3_pkg::*; #(
	parameter int DEPTH  = MAX_WIDTH_DEF,
	parameter int DATA_W = 2 * SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/gm3_window.sv
module gm3_window import gm3_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic [SAMPLE_BITS-1:0]        up2,
	input  logic [SAMPLE_BITS-1:0]        up1,
	input  logic [SAMPLE_BITS-1:0]        smp,
	output logic signed [SAMPLE_BITS+2:0] sx,
	output logic signed [SAMPLE_BITS+2:0] sy
);

	localparam int SW = SAMPLE_BITS + 3;

	// win_q[row*3+col], row 0 on top, col 0 on the left
	logic [SAMPLE_BITS-1:0] win_q [9];
	logic [SW-1:0]          e [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up2;
			win_q[5] <= up1;
			win_q[8] <= smp;
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			e[i] = SW'(win_q[i]);
		end
	end

	// Right minus left, bottom minus top
	assign sx = $signed(e[2] - e[0] + e[5] - e[3] + e[8] - e[6]);
	assign sy = $signed(e[6] - e[0] + e[7] - e[1] + e[8] - e[2]);

endmodule

// File: rtl/core/gm3_magnitude.sv
module gm3_magnitude import gm3_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS+2:0] sx,
	input  logic signed [SAMPLE_BITS+2:0] sy,
	output logic                          done,
	output logic [OUT_W-1:0]              grad
);

	localparam int SW     = SAMPLE_BITS + 3;
	localparam int SQ_W   = 2 * SAMPLE_BITS + 4;
	localparam int SUM_W  = SQ_W + 1;
	localparam int ROOT_W = SAMPLE_BITS + 7;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 1;
	localparam int CNT_W  = $clog2(ROOT_W);
	localparam int QW     = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;

	// Division by the constant: rounded-up reciprocal, three guard bits past the root width
	localparam int DIV_SHIFT = ROOT_W + 3;
	localparam int RCP_W     = DIV_SHIFT - 1;
	localparam int PROD_W    = ROOT_W + DIV_SHIFT;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	mag_state_t state_q, state_d;

	logic signed [SW-1:0]   sx_q, sy_q;
	logic signed [2*SW-1:0] px, py;
	logic [SQ_W-1:0]        sqx_q, sqy_q;
	logic [SUM_W-1:0]       sum;
	logic [RAD_W-1:0]       rad_q;
	logic [REM_W-1:0]       rem_q;
	logic [ROOT_W-1:0]      root_q, quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   last_step;

	logic [REM_W+1:0]       rem_t, trial, diff;
	logic                   ge;
	logic [PROD_W-1:0]      prod;
	logic [QW-1:0]          quo_ext;

	assign px  = sx_q * sx_q;
	assign py  = sy_q * sy_q;
	assign sum = SUM_W'(sqx_q) + SUM_W'(sqy_q);

	// One root bit per cycle: bring down two radicand bits, try 4*root+1
	assign rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = (REM_W+2)'({root_q, 2'b01});
	assign ge    = (rem_t >= trial);
	assign diff  = rem_t - trial;

	// Quotient by six: multiply by the reciprocal, drop the low bits
	assign prod = PROD_W'(root_q) * PROD_W'(RECIP);

	assign last_step = (cnt_q == CNT_W'(ROOT_W - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			MG_IDLE: if (start) state_d = MG_SQ;
			MG_SQ:   state_d = MG_SUM;
			MG_SUM:  state_d = MG_ROOT;
			MG_ROOT: if (last_step) state_d = MG_DIV;
			MG_DIV:  state_d = MG_DONE;
			MG_DONE: state_d = MG_IDLE;
			default: state_d = MG_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			MG_DONE: done = 1'b1;
			default: done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MG_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == MG_ROOT && !last_step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MG_IDLE: begin
				if (start) begin
					sx_q <= sx;
					sy_q <= sy;
				end
			end
			MG_SQ: begin
				sqx_q <= px[SQ_W-1:0];
				sqy_q <= py[SQ_W-1:0];
			end
			MG_SUM: begin
				rad_q  <= RAD_W'({sum, {FRAC_SHIFT{1'b0}}});
				rem_q  <= '0;
				root_q <= '0;
			end
			MG_ROOT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], ge};
			end
			MG_DIV: begin
				quo_q <= prod[DIV_SHIFT +: ROOT_W];
			end
			default: ;
		endcase
	end

	assign quo_ext = QW'(quo_q);
	assign grad    = (quo_ext > QW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(quo_ext);

endmodule

// File: rtl/core/gradient_magnitude_3x3_core.sv
// 3x3 Prewitt gradient magnitude over a raster pixel stream. Send one sample per
// beat on the s_ side, with s_tuser high on the first pixel of a frame; each pixel
// at row r>=1, column c>=1 yields one beat on the m_ side for centre (r-1, c-1),
// carrying floor(sqrt(sx^2+sy^2)*16/6) with four fraction bits, 0 on the first row
// and column, and m_tlast on the last centre of the frame. The last row and column
// of centres are never sent. frame_width and frame_height (APB, byte addresses 0
// and 4) are clamped to [3, MAX_WIDTH] and [3, 4096]; write them only while the
// block is idle. Items are handled one at a time: the line store is read on the
// accept edge and written back in the following cycle. An item with no result
// ends there; a border centre then passes through the output state, and an
// interior centre first runs the bit-serial square root, which yields one root
// bit per cycle, followed by a reciprocal multiply for the division by six. A
// finished result waits in the output register while the next item is taken.
module gradient_magnitude_3x3_core import gm3_pkg::*; #(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	// pixel input
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [7:0] sample
	input  logic                 s_tuser,  // [0] frame_start
	// gradient output
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [11:0] gradient_q4, [15:12] zero
	output logic                 m_tlast   // frame_last
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int WCMP  = (WW > FW_W) ? WW : FW_W;
	localparam int MEM_W = 2 * SAMPLE_BITS;
	localparam int SW    = SAMPLE_BITS + 3;

	core_state_t state_q, state_d;

	// Configuration registers
	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic            cfg_wr;
	reg_idx_t        cfg_idx;

	// Frame position
	logic [COL_W-1:0] col_q, col_raw, col_c, w_last;
	logic [ROW_W-1:0] row_q, row_raw, row_c, h_last;
	logic [WCMP-1:0]  fw_ext, eff_w;
	logic [FH_W-1:0]  eff_h;

	// Item in flight
	logic [COL_W-1:0]       col_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic                   last_q;
	logic [OUT_W-1:0]       res_q;

	logic emit, interior, at_last;
	logic accept, mem_rd, mem_wr, win_shift, mag_start, out_free;

	// Line store: low half row r-1, high half row r-2 of the same column
	logic [MEM_W-1:0]       rd_data;
	logic [SAMPLE_BITS-1:0] up1, up2;

	logic signed [SW-1:0] sx, sy;
	logic                 mag_done;
	logic [OUT_W-1:0]     mag_grad;

	logic                 m_tvalid_q, m_tlast_q;
	logic [OUT_W-1:0]     m_grad_q;

	//--------------------------------------------------------------------------
	// APB registers; decode on paddr[2] only
	//--------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_W'(FW_RESET);
			fh_q <= FH_W'(FH_RESET);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FRAME_WIDTH:  fw_q <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FRAME_WIDTH:  prdata = PDATA_W'(fw_q);
			REG_FRAME_HEIGHT: prdata = PDATA_W'(fh_q);
			default:          prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------------
	// Effective frame size and clamped position of the arriving pixel
	//--------------------------------------------------------------------------
	assign fw_ext = WCMP'(fw_q);

	always_comb begin
		if (fw_ext < WCMP'(MIN_SIZE))       eff_w = WCMP'(MIN_SIZE);
		else if (fw_ext > WCMP'(MAX_WIDTH)) eff_w = WCMP'(MAX_WIDTH);
		else                                eff_w = fw_ext;
		if (fh_q < FH_W'(MIN_SIZE))         eff_h = FH_W'(MIN_SIZE);
		else if (fh_q > FH_W'(MAX_HEIGHT))  eff_h = FH_W'(MAX_HEIGHT);
		else                                eff_h = fh_q;
	end

	assign w_last = COL_W'(eff_w - 1'b1);
	assign h_last = ROW_W'(eff_h - 1'b1);

	// frame_start restarts at the top-left; a count past a shrunk frame ends it there
	assign col_raw = s_tuser ? '0 : col_q;
	assign row_raw = s_tuser ? '0 : row_q;
	assign col_c   = (col_raw > w_last) ? w_last : col_raw;
	assign row_c   = (row_raw > h_last) ? h_last : row_raw;

	//--------------------------------------------------------------------------
	// Sequencer
	//--------------------------------------------------------------------------
	assign emit     = (row_s1 != '0) && (col_s1 != '0);
	assign interior = (row_s1 >= ROW_W'(2)) && (col_s1 >= COL_W'(2));
	assign at_last  = (row_s1 == h_last) && (col_s1 == w_last);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_RMW;
			ST_RMW: begin
				if (!emit)         state_d = ST_IDLE;
				else if (interior) state_d = ST_MAG;
				else               state_d = ST_OUT;
			end
			ST_MAG:  state_d = ST_WAIT;
			ST_WAIT: if (mag_done) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		win_shift = 1'b0;
		mem_wr    = 1'b0;
		mag_start = 1'b0;
		case (state_q)
			ST_IDLE: s_tready  = 1'b1;
			ST_RMW: begin
				win_shift = 1'b1;
				mem_wr    = 1'b1;
			end
			ST_MAG:  mag_start = 1'b1;
			default: ;
		endcase
	end

	assign accept = s_tvalid & s_tready;
	// Read only on accept; the write-back lands in the following cycle, before the next read
	assign mem_rd = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			// Advance the raster position once the column has been written back
			if (state_q == ST_RMW) begin
				if (col_s1 == w_last) begin
					col_q <= '0;
					row_q <= (row_s1 == h_last) ? '0 : row_s1 + 1'b1;
				end else begin
					col_q <= col_s1 + 1'b1;
					row_q <= row_s1;
				end
			end
		end
	end

	// Capture the accepted beat; hold the result until the output register frees
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col_c;
			row_s1 <= row_c;
			smp_s1 <= SAMPLE_BITS'(s_tdata);
		end
		if (state_q == ST_RMW) begin
			last_q <= at_last;
			res_q  <= '0;
		end
		if (state_q == ST_WAIT && mag_done) begin
			res_q <= mag_grad;
		end
	end

	//--------------------------------------------------------------------------
	// Line store and window
	//--------------------------------------------------------------------------
	assign up1 = rd_data[SAMPLE_BITS-1:0];
	assign up2 = rd_data[MEM_W-1:SAMPLE_BITS];

	gm3_line_store #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (MEM_W)
	) u_line_store (
		.clk     (clk),
		.rd_en   (mem_rd),
		.rd_addr (col_c),
		.rd_data (rd_data),
		.wr_en   (mem_wr),
		.wr_addr (col_s1),
		.wr_data ({up1, smp_s1})
	);

	gm3_window #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (win_shift),
		.up2    (up2),
		.up1    (up1),
		.smp    (smp_s1),
		.sx     (sx),
		.sy     (sy)
	);

	gm3_magnitude #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_magnitude (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mag_start),
		.sx     (sx),
		.sy     (sy),
		.done   (mag_done),
		.grad   (mag_grad)
	);

	//--------------------------------------------------------------------------
	// Output register
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_grad_q  <= res_q;
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_grad_q);
	assign m_tlast  = m_tlast_q;

endmodule

// File: rtl/core/gm3_checker.sv
module gm3_checker import gm3_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tlast,
	input logic [PDATA_W-1:0]   prdata
);

	// A stalled output beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// One item at a time: no beat is taken on the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// Gradient fits its field; the pad bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:OUT_W] == '0)
		else $error("nonzero pad bits in output beat");

	// Register readback never shows bits above the widest register
	a_rd_width: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[PDATA_W-1:FH_W] == '0)
		else $error("register readback wider than register");

endmodule

bind gradient_magnitude_3x3_core gm3_checker u_gm3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.prdata   (prdata)
);
